>>> src/srbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store for the sorted range search core.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package srbs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LEN_W       = IDX_W + 1;
  localparam int PTR_W       = IDX_W + 2;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 11;
  localparam int ELEM_IDX_W  = 10;
  localparam int OUT_W       = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [PTR_W-1:0] ptr_t;
  localparam ptr_t PTR_NONE = '1;

  // Step addresses of the control program.
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_INIT   = 3'd1;
  localparam step_t ST_PROBE1 = 3'd2;
  localparam step_t ST_CMP1   = 3'd3;
  localparam step_t ST_SWAP   = 3'd4;
  localparam step_t ST_PROBE2 = 3'd5;
  localparam step_t ST_CMP2   = 3'd6;
  localparam step_t ST_EMIT   = 3'd7;

  typedef enum logic [1:0] {
    C_NEVER,
    C_ALWAYS,
    C_EMPTY,
    C_NO_QUERY
  } cond_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_INIT,
    DP_PROBE,
    DP_CMP,
    DP_SWAP,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   lean_left;
    logic   track_bound;
    cond_t  cond;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic query_go;
  } status_t;

  // Control store: a jump to target is taken when cond holds, else the step advances.
  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    begin
      unique case (s)
        ST_IDLE:   w = '{op: DP_NOP,   lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_NO_QUERY, target: ST_IDLE};
        ST_INIT:   w = '{op: DP_INIT,  lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_NEVER,    target: ST_IDLE};
        ST_PROBE1: w = '{op: DP_PROBE, lean_left: 1'b1, track_bound: 1'b1,
                         cond: C_EMPTY,    target: ST_SWAP};
        ST_CMP1:   w = '{op: DP_CMP,   lean_left: 1'b1, track_bound: 1'b1,
                         cond: C_ALWAYS,   target: ST_PROBE1};
        ST_SWAP:   w = '{op: DP_SWAP,  lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_NEVER,    target: ST_IDLE};
        ST_PROBE2: w = '{op: DP_PROBE, lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_EMPTY,    target: ST_EMIT};
        ST_CMP2:   w = '{op: DP_CMP,   lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_ALWAYS,   target: ST_PROBE2};
        ST_EMIT:   w = '{op: DP_EMIT,  lean_left: 1'b0, track_bound: 1'b0,
                         cond: C_ALWAYS,   target: ST_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

>>> src/srbs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds no reset and no clearing logic.
module srbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/srbs_seq.sv
`timescale 1ns / 1ps
// Step counter and control store readout for the sorted range search core.
// Depends on srbs_pkg for the control word, status and step addresses.
module srbs_seq
  import srbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl,
  output logic    busy
);

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_EMPTY:    take = status.empty;
      C_NO_QUERY: take = !status.query_go;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : step_t'(pc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy = (pc_r != ST_IDLE);

endmodule

>>> src/srbs_dp.sv
`timescale 1ns / 1ps
// Search datapath: bounds, midpoint, compare, hit and bound tracking, result registers.
// Depends on srbs_pkg; driven by the control word from srbs_seq.
module srbs_dp
  import srbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  input  logic                     query_go,
  input  logic signed [DATA_W-1:0] search_target,
  input  logic [CFG_W-1:0]         array_length,
  input  logic [DATA_W-1:0]        rd_data,
  output logic [IDX_W-1:0]         rd_addr,
  output logic                     empty,
  output logic                     out_strobe,
  output logic signed [OUT_W-1:0]  out_first_index,
  output logic signed [OUT_W-1:0]  out_last_index
);

  logic signed [DATA_W-1:0] target_r, target_nxt;
  ptr_t lo_r, lo_nxt;
  ptr_t hi_r, hi_nxt;
  ptr_t tight_r, tight_nxt;
  ptr_t hit_r, hit_nxt;
  ptr_t hi_full_r, hi_full_nxt;
  ptr_t first_r, first_nxt;
  ptr_t mid_r, mid_nxt;
  logic out_strobe_r, out_strobe_nxt;
  logic signed [OUT_W-1:0] out_first_r, out_first_nxt;
  logic signed [OUT_W-1:0] out_last_r, out_last_nxt;

  logic [LEN_W-1:0] len_clamped;
  ptr_t hi_init;
  ptr_t mid_calc;
  ptr_t mid_m1;
  ptr_t mid_p1;
  logic signed [DATA_W-1:0] value;
  logic lt;
  logic gt;

  // A length above the store depth searches the whole store.
  assign len_clamped = (32'(array_length) > 32'(STORE_DEPTH)) ?
                       LEN_W'(STORE_DEPTH) : LEN_W'(array_length);
  assign hi_init  = ptr_t'({1'b0, len_clamped}) - ptr_t'(1);
  assign empty    = (lo_r > hi_r);
  assign mid_calc = lo_r + ((hi_r - lo_r) >>> 1);
  assign rd_addr  = mid_calc[IDX_W-1:0];
  assign mid_m1   = mid_r - ptr_t'(1);
  assign mid_p1   = mid_r + ptr_t'(1);
  assign value    = $signed(rd_data);
  assign lt       = (value < target_r);
  assign gt       = (value > target_r);
  assign target_nxt = query_go ? search_target : target_r;

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    tight_nxt      = tight_r;
    hit_nxt        = hit_r;
    hi_full_nxt    = hi_full_r;
    first_nxt      = first_r;
    mid_nxt        = mid_r;
    out_strobe_nxt = 1'b0;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    unique case (ctrl.op)
      DP_NOP: begin
      end
      DP_INIT: begin
        lo_nxt      = '0;
        hi_nxt      = hi_init;
        tight_nxt   = hi_init;
        hi_full_nxt = hi_init;
        hit_nxt     = PTR_NONE;
      end
      DP_PROBE: begin
        mid_nxt = mid_calc;
      end
      DP_CMP: begin
        if (lt) begin
          lo_nxt = mid_p1;
        end else if (gt) begin
          hi_nxt = mid_m1;
          if (ctrl.track_bound) begin
            tight_nxt = mid_m1;
          end
        end else begin
          hit_nxt = mid_r;
          if (ctrl.lean_left) begin
            hi_nxt = mid_m1;
          end else begin
            lo_nxt = mid_p1;
          end
        end
      end
      DP_SWAP: begin
        // The second pass runs from the first hit (index 0 without one) up to the tightest right bound.
        first_nxt = hit_r;
        lo_nxt    = (hit_r == PTR_NONE) ? ptr_t'(0) : hit_r;
        hi_nxt    = (tight_r == PTR_NONE) ? hi_full_r : tight_r;
        hit_nxt   = PTR_NONE;
      end
      DP_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_first_nxt  = OUT_W'(first_r);
        out_last_nxt   = OUT_W'(hit_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    tight_r     <= tight_nxt;
    hit_r       <= hit_nxt;
    hi_full_r   <= hi_full_nxt;
    first_r     <= first_nxt;
    mid_r       <= mid_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_first_index = out_first_r;
  assign out_last_index  = out_last_r;

`ifndef SYNTHESIS
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_CMP) |-> (mid_r >= lo_r && mid_r <= hi_r))
    else $error("probed index left the search window");

  a_hit_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_EMIT) |->
      (hit_r == PTR_NONE || (hit_r >= ptr_t'(0) && hit_r <= ptr_t'(STORE_DEPTH - 1))))
    else $error("last hit outside the store");

  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(ctrl.op == DP_EMIT))
    else $error("result strobe without an emit step");
`endif

endmodule

>>> src/sorted_range_binary_search_core.sv
`timescale 1ns / 1ps
// Top level of the sorted range search core: store RAM, sequencer and datapath.
// Depends on srbs_pkg, srbs_ram, srbs_seq and srbs_dp.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// A write item (in_operation = 0) stores in_element_value at in_element_index
// in that same edge, produces no result and leaves busy low, so writes can
// stream one per cycle. A query item (in_operation = 1) raises busy and runs
// two binary searches over the first array_length entries: a left-leaning one
// for the first index and a right-leaning one for the last index.
// cfg_wr_en with cfg_wr_data sets array_length; write it only while idle.
// Each probe has two steps (address, then registered RAM read and compare).
// A query holds busy through the init step, both probe passes, the swap and
// the emit step; out_strobe then pulses high, registered from that step, in the
// same cycle in which busy is low again.
// With 1024 entries each pass makes at most 11 probes.
// The result cannot be held off; the out_ ports hold it until the next result.
// Reset clears the sequencer, the strobe and array_length; store contents
// are kept and an entry reads as garbage until it has been written.
module sorted_range_binary_search_core
  import srbs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic [ELEM_IDX_W-1:0]        in_element_index,
  input  logic signed [DATA_W-1:0]     in_element_value,
  input  logic signed [DATA_W-1:0]     in_search_target,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  output logic                         out_strobe,
  output logic signed [OUT_W-1:0]      out_first_index,
  output logic signed [OUT_W-1:0]      out_last_index
);

  logic [CFG_W-1:0]  array_length_r;
  logic              accept;
  logic              ram_we;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  ctrl_t             ctrl;
  status_t           status;
  logic              empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else if (cfg_wr_en) begin
      array_length_r <= cfg_wr_data;
    end
  end

  assign accept          = start && !busy;
  assign status.query_go = accept && (in_operation == OP_QUERY);
  assign status.empty    = empty;
  // Writes beyond the store are dropped.
  assign ram_we = accept && (in_operation == OP_WRITE) &&
                  (32'(in_element_index) < 32'(STORE_DEPTH));

  srbs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (IDX_W'(in_element_index)),
    .wr_data (in_element_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srbs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  srbs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .query_go        (status.query_go),
    .search_target   (in_search_target),
    .array_length    (array_length_r),
    .rd_data         (rd_data),
    .rd_addr         (rd_addr),
    .empty           (empty),
    .out_strobe      (out_strobe),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index)
  );

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_QUERY) |=> busy)
    else $error("query item accepted but core not busy");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_WRITE) |=> !busy)
    else $error("write item made the core busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a query");
`endif

endmodule
